@@ hw/rtl/least_squares_line_fit_eval_defines.svh @@
// Assertion macros for the line fit block.
`ifndef LEAST_SQUARES_LINE_FIT_EVAL_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_EVAL_DEFINES_SVH

// Same-cycle implication.
`define LSF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsf assertion failed");

// Next-cycle implication.
`define LSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsf assertion failed");

`endif

@@ hw/rtl/lsf_pkg.sv @@
// Shared types and constants of the line fit block.
`default_nettype none
package lsf_pkg;
   localparam int POINTS_DEF = 4;
   localparam int XW = 24;
   localparam int SW = 27;
   localparam int PW = 50;
   localparam int MW = 27;
   localparam int MPW = 2 * MW;
   localparam int DENW = 56;
   localparam int ACCW = 80;
   localparam int QW = 26;
   localparam int QMW = 25;
   localparam int SPLIT = 25;
   localparam int FRAC = 12;
   localparam int SCALE_MUL = 621;
   localparam int SCALE_DIV = 1000;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_NOT_READY = 2'd2,
      STAT_DEGEN = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_CLEAR,
      OP_LD_SCALE, OP_DIV_X, OP_X_TAKE,
      OP_Q_SCALE, OP_DIV_Q, OP_Q_TAKE,
      OP_LD_XX, OP_LD_XY, OP_LD_ACC,
      OP_FIT_SXSX, OP_FIT_DEN, OP_FIT_DEGEN, OP_FIT_SXSY, OP_FIT_SNUM,
      OP_DIV_SLOPE, OP_SLOPE_TAKE,
      OP_IN_M1, OP_IN_M2, OP_IN_M3, OP_IN_M4, OP_IN_M5,
      OP_DIV_ICPT, OP_ICPT_TAKE,
      OP_Q_MUL, OP_Q_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic miles;
      logic count_full;
      logic den_zero;
      logic div_done;
      logic rsp_free;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LD_SCALE, S_LD_DIV_GO, S_LD_DIV_WAIT,
      S_LD_XX, S_LD_XY, S_LD_ACC, S_LD_DONE,
      S_FIT_SXSX, S_FIT_DEN, S_FIT_CHECK, S_FIT_SXSY, S_FIT_SNUM,
      S_SLOPE_GO, S_SLOPE_WAIT,
      S_IN_M1, S_IN_M2, S_IN_M3, S_IN_M4, S_IN_M5,
      S_ICPT_GO, S_ICPT_WAIT,
      S_Q_SCALE, S_Q_DIV_GO, S_Q_DIV_WAIT, S_Q_MUL, S_Q_OUT
   } ctrl_state_type;
endpackage
`default_nettype wire

@@ hw/rtl/lsf_intf.sv @@
// Channel interfaces of the line fit block.
`default_nettype none
interface lsf_req_if;
   import lsf_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] command;
   logic signed [XW-1:0] x_value;
   logic signed [XW-1:0] y_value;
   logic signed [XW-1:0] query_value;
   logic query_other_unit;
   modport source(output valid, command, x_value, y_value, query_value, query_other_unit,
                  input ready);
   modport sink(input valid, command, x_value, y_value, query_value, query_other_unit,
                output ready);
endinterface

interface lsf_rsp_if;
   import lsf_pkg::*;
   logic valid;
   logic ready;
   logic signed [XW-1:0] ratio;
   logic [1:0] status;
   modport source(output valid, ratio, status, input ready);
   modport sink(input valid, ratio, status, output ready);
endinterface

interface lsf_csr_if;
   logic valid;
   logic ready;
   logic model_in_miles;
   modport source(output valid, model_in_miles, input ready);
   modport sink(input valid, model_in_miles, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lsf_div.sv @@
// Restoring signed divider, one quotient bit per cycle.
`default_nettype none
module lsf_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [lsf_pkg::ACCW-1:0] num,
   input  logic signed [lsf_pkg::DENW-1:0] den,
   output logic done,
   output logic neg,
   output logic ovf,
   output logic [lsf_pkg::QMW-1:0] mag
);
   import lsf_pkg::*;
   localparam int CNTW = $clog2(ACCW + 1);

   logic busy_ff, busy_in, done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [ACCW-1:0] num_ff, num_in;
   logic [DENW-1:0] den_ff, den_in;
   logic [DENW:0] rem_ff, rem_in, rem_sh;
   logic [QMW-1:0] quot_ff, quot_in;
   logic ovf_ff, ovf_in, neg_ff, neg_in, ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      ovf_in = ovf_ff;
      neg_in = neg_ff;
      rem_sh = {rem_ff[DENW-1:0], num_ff[ACCW-1]};
      ge = rem_sh >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNTW'(ACCW);
         num_in = num[ACCW-1] ? -num : num;
         den_in = den[DENW-1] ? -den : den;
         rem_in = '0;
         quot_in = '0;
         ovf_in = 1'b0;
         neg_in = num[ACCW-1] ^ den[DENW-1];
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         num_in = {num_ff[ACCW-2:0], 1'b0};
         quot_in = {quot_ff[QMW-2:0], ge};
         ovf_in = ovf_ff | quot_ff[QMW-1];
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign neg = neg_ff;
   assign ovf = ovf_ff;
   assign mag = quot_ff;
endmodule
`default_nettype wire

@@ hw/rtl/lsf_dp.sv @@
// Datapath: sums, bounds, fit registers, shared multiplier and divider, result register.
`default_nettype none
module lsf_dp #(
   parameter int POINTS = lsf_pkg::POINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  lsf_pkg::dp_cmd_type cmd,
   output lsf_pkg::dp_stat_type stat,
   input  logic csr_valid,
   input  logic csr_data,
   input  logic signed [lsf_pkg::XW-1:0] req_x,
   input  logic signed [lsf_pkg::XW-1:0] req_y,
   input  logic signed [lsf_pkg::XW-1:0] req_q,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [lsf_pkg::XW-1:0] rsp_ratio,
   output logic [1:0] rsp_status
);
   import lsf_pkg::*;
   localparam int CNTW = $clog2(POINTS + 1);
   localparam int EVW = MPW - FRAC + 1;
   localparam logic signed [XW-1:0] Q_MAX = {1'b0, {(XW-1){1'b1}}};
   localparam logic signed [XW-1:0] Q_MIN = {1'b1, {(XW-1){1'b0}}};
   // unit scaling divide by 1000 or 621 through a reciprocal, split in two 17-bit halves
   localparam int CDN = 33;
   localparam int CDK = 17;
   localparam int CDKW = 2 * CDK;
   localparam int CDS = 43;
   localparam int CDP = CDN + CDK;
   localparam int CDT = CDP + CDK;
   localparam logic [63:0] CD_ONE = 64'd1 << CDS;
   localparam logic [CDKW-1:0] RCP_DIV =
      CDKW'((CD_ONE + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));
   localparam logic [CDKW-1:0] RCP_MUL =
      CDKW'((CD_ONE + 64'(SCALE_MUL) - 64'd1) / 64'(SCALE_MUL));

   logic miles_ff, miles_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic signed [SW-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [PW-1:0] sum_xx_ff, sum_xx_in, sum_xy_ff, sum_xy_in;
   logic signed [XW-1:0] low_ff, low_in, high_ff, high_in;
   logic signed [XW-1:0] slope_ff, slope_in, icpt_ff, icpt_in;
   status_type fit_ff, fit_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [QW-1:0] q_ff, q_in;
   logic signed [MPW-1:0] prod_ff, mul_p;
   logic signed [DENW-1:0] den_ff, den_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [XW-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic signed [MW-1:0] mul_a, mul_b;
   logic mul_en;
   logic div_start, div_done, div_neg, div_ovf;
   logic [QMW-1:0] div_mag;
   logic signed [ACCW-1:0] div_num;
   logic signed [DENW-1:0] div_den;
   logic signed [XW-1:0] div_sat;
   logic signed [MPW-1:0] trunc_p;
   logic signed [EVW-1:0] ev;
   logic signed [XW-1:0] ev_sat;
   logic out_of_range;
   logic [CDN-1:0] cd_mag_ff, cd_mag_in;
   logic cd_neg_ff, cd_neg_in, cd_rcp_mul_ff, cd_rcp_mul_in;
   logic cd_st1_ff, cd_st1_in, cd_st2_ff;
   logic [CDP-1:0] cd_hi_ff, cd_lo_ff;
   logic [CDKW-1:0] cd_rcp;
   logic [MPW-1:0] cd_abs;
   logic [CDT-1:0] cd_sum;
   logic signed [QW-1:0] cd_q;

   assign mul_p = mul_a * mul_b;

   always_comb begin
      cd_abs = prod_ff[MPW-1] ? -prod_ff : prod_ff;
      cd_rcp = cd_rcp_mul_ff ? RCP_MUL : RCP_DIV;
      cd_sum = (CDT'(cd_hi_ff) << CDK) + CDT'(cd_lo_ff);
      cd_q = cd_neg_ff ? -QW'(cd_sum[CDT-1:CDS]) : QW'(cd_sum[CDT-1:CDS]);
   end

   always_comb begin
      if (div_neg) begin
         div_sat = (div_ovf || div_mag > QMW'(2 ** (XW - 1))) ? Q_MIN : -XW'(div_mag);
      end else begin
         div_sat = (div_ovf || div_mag > QMW'(Q_MAX)) ? Q_MAX : XW'(div_mag);
      end
   end

   always_comb begin
      trunc_p = prod_ff[MPW-1] ? (prod_ff + MPW'((1 << FRAC) - 1)) >>> FRAC
                               : prod_ff >>> FRAC;
      ev = EVW'(trunc_p) + EVW'(icpt_ff);
      if (ev > EVW'(Q_MAX)) begin
         ev_sat = Q_MAX;
      end else if (ev < EVW'(Q_MIN)) begin
         ev_sat = Q_MIN;
      end else begin
         ev_sat = XW'(ev);
      end
      out_of_range = (q_ff < QW'(low_ff)) || (q_ff > QW'(high_ff));
   end

   always_comb begin
      miles_in = csr_valid ? csr_data : miles_ff;
      cnt_in = cnt_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_xx_in = sum_xx_ff;
      sum_xy_in = sum_xy_ff;
      low_in = low_ff;
      high_in = high_ff;
      slope_in = slope_ff;
      icpt_in = icpt_ff;
      fit_in = fit_ff;
      x_in = x_ff;
      y_in = y_ff;
      q_in = q_ff;
      den_in = den_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_status_in = rsp_status_ff;
      mul_a = '0;
      mul_b = '0;
      mul_en = 1'b0;
      div_start = 1'b0;
      div_num = acc_ff;
      div_den = den_ff;
      cd_mag_in = cd_mag_ff;
      cd_neg_in = cd_neg_ff;
      cd_rcp_mul_in = cd_rcp_mul_ff;
      cd_st1_in = 1'b0;
      case (cmd.op)
         OP_CAPTURE: begin
            x_in = req_x;
            y_in = req_y;
            q_in = QW'(req_q);
         end
         OP_CLEAR: begin
            cnt_in = '0;
            sum_x_in = '0;
            sum_y_in = '0;
            sum_xx_in = '0;
            sum_xy_in = '0;
            low_in = '0;
            high_in = '0;
            slope_in = '0;
            icpt_in = '0;
            fit_in = STAT_NOT_READY;
         end
         OP_LD_SCALE: begin
            mul_a = MW'(x_ff);
            mul_b = MW'(SCALE_MUL);
            mul_en = 1'b1;
         end
         OP_DIV_X: begin
            cd_st1_in = 1'b1;
            cd_mag_in = cd_abs[CDN-1:0];
            cd_neg_in = prod_ff[MPW-1];
            cd_rcp_mul_in = 1'b0;
         end
         OP_X_TAKE: x_in = XW'(cd_q);
         OP_Q_SCALE: begin
            mul_a = MW'(q_ff);
            mul_b = miles_ff ? MW'(SCALE_MUL) : MW'(SCALE_DIV);
            mul_en = 1'b1;
         end
         OP_DIV_Q: begin
            cd_st1_in = 1'b1;
            cd_mag_in = cd_abs[CDN-1:0];
            cd_neg_in = prod_ff[MPW-1];
            cd_rcp_mul_in = !miles_ff;
         end
         OP_Q_TAKE: q_in = cd_q;
         OP_LD_XX: begin
            mul_a = MW'(x_ff);
            mul_b = MW'(x_ff);
            mul_en = 1'b1;
         end
         OP_LD_XY: begin
            sum_xx_in = sum_xx_ff + PW'(prod_ff);
            mul_a = MW'(x_ff);
            mul_b = MW'(y_ff);
            mul_en = 1'b1;
         end
         OP_LD_ACC: begin
            sum_xy_in = sum_xy_ff + PW'(prod_ff);
            sum_x_in = sum_x_ff + SW'(x_ff);
            sum_y_in = sum_y_ff + SW'(y_ff);
            if (cnt_ff == '0) begin
               low_in = x_ff;
            end
            high_in = x_ff;
            cnt_in = cnt_ff + CNTW'(1);
         end
         OP_FIT_SXSX: begin
            mul_a = sum_x_ff;
            mul_b = sum_x_ff;
            mul_en = 1'b1;
         end
         OP_FIT_DEN: den_in = DENW'(prod_ff) - DENW'(sum_xx_ff) * DENW'(POINTS);
         OP_FIT_DEGEN: fit_in = STAT_DEGEN;
         OP_FIT_SXSY: begin
            mul_a = sum_x_ff;
            mul_b = sum_y_ff;
            mul_en = 1'b1;
         end
         OP_FIT_SNUM: acc_in = (ACCW'(prod_ff) - ACCW'(sum_xy_ff) * ACCW'(POINTS)) <<< FRAC;
         OP_DIV_SLOPE: div_start = 1'b1;
         OP_SLOPE_TAKE: slope_in = div_sat;
         OP_IN_M1: begin
            mul_a = sum_x_ff;
            mul_b = MW'($signed(sum_xy_ff[PW-1:SPLIT]));
            mul_en = 1'b1;
         end
         OP_IN_M2: begin
            acc_in = ACCW'(prod_ff) <<< SPLIT;
            mul_a = sum_x_ff;
            mul_b = MW'({1'b0, sum_xy_ff[SPLIT-1:0]});
            mul_en = 1'b1;
         end
         OP_IN_M3: begin
            acc_in = acc_ff + ACCW'(prod_ff);
            mul_a = MW'($signed(sum_xx_ff[PW-1:SPLIT]));
            mul_b = sum_y_ff;
            mul_en = 1'b1;
         end
         OP_IN_M4: begin
            acc_in = acc_ff - (ACCW'(prod_ff) <<< SPLIT);
            mul_a = MW'({1'b0, sum_xx_ff[SPLIT-1:0]});
            mul_b = sum_y_ff;
            mul_en = 1'b1;
         end
         OP_IN_M5: acc_in = acc_ff - ACCW'(prod_ff);
         OP_DIV_ICPT: div_start = 1'b1;
         OP_ICPT_TAKE: begin
            icpt_in = div_sat;
            fit_in = STAT_OK;
         end
         OP_Q_MUL: begin
            mul_a = MW'(slope_ff);
            mul_b = MW'(q_ff);
            mul_en = 1'b1;
         end
         OP_Q_OUT: begin
            rsp_valid_in = 1'b1;
            if (fit_ff != STAT_OK) begin
               rsp_status_in = fit_ff;
               rsp_ratio_in = '0;
            end else if (out_of_range) begin
               rsp_status_in = STAT_RANGE;
               rsp_ratio_in = '0;
            end else begin
               rsp_status_in = STAT_OK;
               rsp_ratio_in = ev_sat;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miles_ff <= 1'b0;
         cnt_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_xx_ff <= '0;
         sum_xy_ff <= '0;
         low_ff <= '0;
         high_ff <= '0;
         slope_ff <= '0;
         icpt_ff <= '0;
         fit_ff <= STAT_NOT_READY;
         rsp_valid_ff <= 1'b0;
         cd_st1_ff <= 1'b0;
         cd_st2_ff <= 1'b0;
      end else begin
         miles_ff <= miles_in;
         cnt_ff <= cnt_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_xx_ff <= sum_xx_in;
         sum_xy_ff <= sum_xy_in;
         low_ff <= low_in;
         high_ff <= high_in;
         slope_ff <= slope_in;
         icpt_ff <= icpt_in;
         fit_ff <= fit_in;
         rsp_valid_ff <= rsp_valid_in;
         cd_st1_ff <= cd_st1_in;
         cd_st2_ff <= cd_st1_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      q_ff <= q_in;
      den_ff <= den_in;
      acc_ff <= acc_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_status_ff <= rsp_status_in;
      cd_mag_ff <= cd_mag_in;
      cd_neg_ff <= cd_neg_in;
      cd_rcp_mul_ff <= cd_rcp_mul_in;
      cd_hi_ff <= CDP'(cd_mag_ff) * CDP'(cd_rcp[CDKW-1:CDK]);
      cd_lo_ff <= CDP'(cd_mag_ff) * CDP'(cd_rcp[CDK-1:0]);
      if (mul_en) begin
         prod_ff <= mul_p;
      end
   end

   lsf_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .neg(div_neg),
      .ovf(div_ovf),
      .mag(div_mag)
   );

   always_comb begin
      stat.miles = miles_ff;
      stat.count_full = (cnt_ff == CNTW'(POINTS));
      stat.den_zero = (den_ff == '0);
      stat.div_done = div_done || cd_st2_ff;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ratio = rsp_ratio_ff;
   assign rsp_status = rsp_status_ff;
endmodule
`default_nettype wire

@@ hw/rtl/lsf_ctrl.sv @@
// Controller: sequences load, fit, clear and query operations.
`default_nettype none
module lsf_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic [1:0] req_command,
   input  logic req_other_unit,
   output logic req_ready,
   input  lsf_pkg::dp_stat_type stat,
   output lsf_pkg::dp_cmd_type cmd
);
   import lsf_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  CMD_LOAD: begin
                     cmd.op = OP_CAPTURE;
                     if (!stat.count_full) begin
                        state_in = stat.miles ? S_LD_SCALE : S_LD_XX;
                     end
                  end
                  CMD_QUERY: begin
                     cmd.op = OP_CAPTURE;
                     state_in = req_other_unit ? S_Q_SCALE : S_Q_MUL;
                  end
                  CMD_CLEAR: cmd.op = OP_CLEAR;
                  default: ;
               endcase
            end
         end
         S_LD_SCALE: begin
            cmd.op = OP_LD_SCALE;
            state_in = S_LD_DIV_GO;
         end
         S_LD_DIV_GO: begin
            cmd.op = OP_DIV_X;
            state_in = S_LD_DIV_WAIT;
         end
         S_LD_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.op = OP_X_TAKE;
               state_in = S_LD_XX;
            end
         end
         S_LD_XX: begin
            cmd.op = OP_LD_XX;
            state_in = S_LD_XY;
         end
         S_LD_XY: begin
            cmd.op = OP_LD_XY;
            state_in = S_LD_ACC;
         end
         S_LD_ACC: begin
            cmd.op = OP_LD_ACC;
            state_in = S_LD_DONE;
         end
         S_LD_DONE: state_in = stat.count_full ? S_FIT_SXSX : S_IDLE;
         S_FIT_SXSX: begin
            cmd.op = OP_FIT_SXSX;
            state_in = S_FIT_DEN;
         end
         S_FIT_DEN: begin
            cmd.op = OP_FIT_DEN;
            state_in = S_FIT_CHECK;
         end
         S_FIT_CHECK: begin
            if (stat.den_zero) begin
               cmd.op = OP_FIT_DEGEN;
               state_in = S_IDLE;
            end else begin
               state_in = S_FIT_SXSY;
            end
         end
         S_FIT_SXSY: begin
            cmd.op = OP_FIT_SXSY;
            state_in = S_FIT_SNUM;
         end
         S_FIT_SNUM: begin
            cmd.op = OP_FIT_SNUM;
            state_in = S_SLOPE_GO;
         end
         S_SLOPE_GO: begin
            cmd.op = OP_DIV_SLOPE;
            state_in = S_SLOPE_WAIT;
         end
         S_SLOPE_WAIT: begin
            if (stat.div_done) begin
               cmd.op = OP_SLOPE_TAKE;
               state_in = S_IN_M1;
            end
         end
         S_IN_M1: begin
            cmd.op = OP_IN_M1;
            state_in = S_IN_M2;
         end
         S_IN_M2: begin
            cmd.op = OP_IN_M2;
            state_in = S_IN_M3;
         end
         S_IN_M3: begin
            cmd.op = OP_IN_M3;
            state_in = S_IN_M4;
         end
         S_IN_M4: begin
            cmd.op = OP_IN_M4;
            state_in = S_IN_M5;
         end
         S_IN_M5: begin
            cmd.op = OP_IN_M5;
            state_in = S_ICPT_GO;
         end
         S_ICPT_GO: begin
            cmd.op = OP_DIV_ICPT;
            state_in = S_ICPT_WAIT;
         end
         S_ICPT_WAIT: begin
            if (stat.div_done) begin
               cmd.op = OP_ICPT_TAKE;
               state_in = S_IDLE;
            end
         end
         S_Q_SCALE: begin
            cmd.op = OP_Q_SCALE;
            state_in = S_Q_DIV_GO;
         end
         S_Q_DIV_GO: begin
            cmd.op = OP_DIV_Q;
            state_in = S_Q_DIV_WAIT;
         end
         S_Q_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.op = OP_Q_TAKE;
               state_in = S_Q_MUL;
            end
         end
         S_Q_MUL: begin
            cmd.op = OP_Q_MUL;
            state_in = S_Q_OUT;
         end
         S_Q_OUT: begin
            if (stat.rsp_free) begin
               cmd.op = OP_Q_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ hw/rtl/least_squares_line_fit_eval.sv @@
// Top level of the least-squares line fit and evaluation block.
//
// req_chan carries one transaction per command: load a Q12.12 (x,y) pair,
// query the fitted line at query_value, or clear all sums. Only a query
// gives a transaction on rsp_chan (ratio, status). csr_chan writes the
// model_in_miles bit and is always ready; the user must write it only
// while idle, as the block itself does not enforce this.
// Steps per command: a load scales x to miles first when model_in_miles
// is set; the last of POINTS loads adds the fit (cut short on degenerate
// data) with two passes of the shared restoring divider. A query converts
// the query value first when query_other_unit is set, then registers the
// result once the output register is free. A clear resets the sums.
// One request is worked on at a time; req ready is high only in idle.
// A finished result sits in the output register while the next request is
// taken; if the receiver stalls, a later query waits for that register.
// Reset (synchronous) clears all sums and bounds, marks the fit not ready
// and clears model_in_miles.
`default_nettype none
module least_squares_line_fit_eval #(
   parameter int POINTS = lsf_pkg::POINTS_DEF
) (
   input logic clock,
   input logic reset,
   lsf_req_if.sink req_chan,
   lsf_rsp_if.source rsp_chan,
   lsf_csr_if.sink csr_chan
);
   import lsf_pkg::*;

   dp_cmd_type cmd;
   dp_stat_type stat;

   assign csr_chan.ready = 1'b1;

   lsf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_command(req_chan.command),
      .req_other_unit(req_chan.query_other_unit),
      .req_ready(req_chan.ready),
      .stat(stat),
      .cmd(cmd)
   );

   lsf_dp #(.POINTS(POINTS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .csr_valid(csr_chan.valid),
      .csr_data(csr_chan.model_in_miles),
      .req_x(req_chan.x_value),
      .req_y(req_chan.y_value),
      .req_q(req_chan.query_value),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_ratio(rsp_chan.ratio),
      .rsp_status(rsp_chan.status)
   );
endmodule
`default_nettype wire

@@ hw/rtl/lsf_checker.sv @@
// Port checker for the line fit block, with its bind.
`default_nettype none
`include "least_squares_line_fit_eval_defines.svh"
module lsf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [1:0] req_command,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [lsf_pkg::XW-1:0] rsp_ratio,
   input logic [1:0] rsp_status
);
   import lsf_pkg::*;

   `LSF_ASSERT_IMPLY(a_ratio_zero, clock, reset, rsp_valid && rsp_status != STAT_OK, rsp_ratio == '0)
   `LSF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `LSF_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_command == CMD_QUERY, !req_ready)
   `LSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ratio) && $stable(rsp_status))
endmodule

bind least_squares_line_fit_eval lsf_checker u_lsf_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_command(req_chan.command),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_ratio(rsp_chan.ratio),
   .rsp_status(rsp_chan.status)
);
`default_nettype wire
